FILE: rtl/sdem_pkg.sv
// Shared widths, codes and types of the Sobel directional edge marker.
`default_nettype none

package sdem_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_W      = 11;
  localparam int THR_W      = 8;
  localparam int POS_W      = 10;
  localparam int GRAD_W     = 11;
  localparam int SQ_W       = 2 * (GRAD_W - 1);
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 11'd1024;
  localparam logic [THR_W-1:0] RST_EDGE_THRESHOLD = 8'd20;

  typedef enum logic [1:0] {
    STEP_ZERO,
    STEP_POS,
    STEP_NEG
  } step_t;

  // 3x3 window, index = 3*row + col, row 0 is the oldest line
  typedef struct packed {
    logic [POS_W-1:0]          col;
    logic [POS_W-1:0]          row;
    logic [8:0][PIX_W-1:0]     pix;
  } win_item_t;

endpackage

`default_nettype wire

FILE: rtl/sobel_directional_edge_marker_core.sv
// Top level of the Sobel directional edge marker: counters, line store, window.
//
//  port group | dir | fields (low bit first)
//  in_*       | in  | pixel_value[7:0]
//  out_*      | out | center_col[9:0], center_row[19:10], is_edge[20], zero[23:21]
//  cfg_*      | in  | index 0 image_width, 1 image_height, 2 edge_threshold
//
// One item per cycle while out_tready is high; stages B, C, D, E and output register.
// Line store is one MAX_WIDTH x 16 memory, read at accept, written when the item
// leaves the window stage.
// Synchronous active-low reset clears valids, counters and configuration registers; the line
// store, window and data registers hold no reset value and are not cleared.
// A stalled output backs up through elastic stages; in_tready drops only when full.
`default_nettype none

module sobel_directional_edge_marker_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sdem_pkg::PIX_W-1:0]           in_tdata,   // pixel_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sdem_pkg::OUT_DATA_W-1:0]      out_tdata,  // center_col, center_row, is_edge
  input  logic                                 cfg_we,
  input  logic [sdem_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [sdem_pkg::CFG_W-1:0]           cfg_wdata
);
  import sdem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] img_w_r, img_h_r;
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMAGE_WIDTH;
      img_h_r <= RST_IMAGE_HEIGHT;
      thr_r   <= RST_EDGE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:    img_w_r <= cfg_wdata;
        CFG_IMAGE_HEIGHT:   img_h_r <= cfg_wdata;
        CFG_EDGE_THRESHOLD: thr_r   <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [31:0] w_ext, h_ext;
  logic [CW:0] w_lim;
  logic [RW:0] h_lim;
  always_comb begin
    w_ext = 32'(img_w_r);
    if (w_ext < 32'd3) w_ext = 32'd3;
    else if (w_ext > 32'(MAX_WIDTH)) w_ext = 32'(MAX_WIDTH);
    h_ext = 32'(img_h_r);
    if (h_ext < 32'd3) h_ext = 32'd3;
    else if (h_ext > 32'(MAX_HEIGHT)) h_ext = 32'(MAX_HEIGHT);
    w_lim = w_ext[CW:0];
    h_lim = h_ext[RW:0];
  end

  // pixel position counters
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic          emit;
  logic [31:0]   ccol_full, crow_full;
  logic          in_acc;

  always_comb begin
    col_inc = {1'b0, col_r} + 1'b1;
    row_inc = {1'b0, row_r} + 1'b1;
    if (col_inc >= w_lim) begin
      col_nxt = '0;
      row_nxt = (row_inc >= h_lim) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
    emit = (col_r >= CW'(2)) && ({1'b0, col_r} < w_lim)
        && (row_r >= RW'(2)) && ({1'b0, row_r} < h_lim);
    ccol_full = 32'(col_r) - 32'd1;
    crow_full = 32'(row_r) - 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // stage B: line store data back, window shift, write-back
  logic                  b_v_r, b_emit_r;
  logic [PIX_W-1:0]      b_pix_r;
  logic [CW-1:0]         b_col_r;
  logic [POS_W-1:0]      b_ccol_r, b_crow_r;
  logic [2*PIX_W-1:0]    rd_r;
  logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];
  logic [8:0][PIX_W-1:0] win_r, win_new;
  logic                  fire_b, pipe_ready;
  win_item_t             pipe_item;

  assign fire_b    = b_v_r && (!b_emit_r || pipe_ready);
  assign in_tready = !b_v_r || fire_b;
  assign in_acc    = in_tvalid && in_tready;

  // entry: [7:0] older line, [15:8] newer line
  always_ff @(posedge clk) begin
    if (in_acc) rd_r <= line_mem[col_r];
    if (fire_b) line_mem[b_col_r] <= {b_pix_r, rd_r[2*PIX_W-1:PIX_W]};
  end

  always_comb begin
    win_new[0] = win_r[1];
    win_new[1] = win_r[2];
    win_new[2] = rd_r[PIX_W-1:0];
    win_new[3] = win_r[4];
    win_new[4] = win_r[5];
    win_new[5] = rd_r[2*PIX_W-1:PIX_W];
    win_new[6] = win_r[7];
    win_new[7] = win_r[8];
    win_new[8] = b_pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (in_tready) begin
      b_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_emit_r <= emit;
      b_pix_r  <= in_tdata;
      b_col_r  <= col_r;
      b_ccol_r <= ccol_full[POS_W-1:0];
      b_crow_r <= crow_full[POS_W-1:0];
    end
    if (fire_b) win_r <= win_new;
  end

  always_comb begin
    pipe_item.col = b_ccol_r;
    pipe_item.row = b_crow_r;
    pipe_item.pix = win_new;
  end

  sdem_edge_pipe u_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .thr     (thr_r),
    .s_valid (b_v_r && b_emit_r),
    .s_ready (pipe_ready),
    .s_item  (pipe_item),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: rtl/sdem_edge_pipe.sv
// Gradient, direction and neighbor compare pipeline of the edge marker.
`default_nettype none

module sdem_edge_pipe (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [sdem_pkg::THR_W-1:0]           thr,
  input  logic                                 s_valid,
  output logic                                 s_ready,
  input  sdem_pkg::win_item_t                  s_item,
  output logic                                 m_valid,
  input  logic                                 m_ready,
  output logic [sdem_pkg::OUT_DATA_W-1:0]      m_data
);
  import sdem_pkg::*;

  function automatic logic signed [GRAD_W-1:0] sx(input logic [PIX_W-1:0] p);
    return $signed({{(GRAD_W - PIX_W){1'b0}}, p});
  endfunction

  // stage C: gradients
  logic                     c_v_r;
  logic signed [GRAD_W-1:0] c_fx_r, c_fy_r;
  logic [8:0][PIX_W-1:0]    c_pix_r;
  logic [POS_W-1:0]         c_col_r, c_row_r;
  // stage D: squares
  logic                     d_v_r;
  logic [SQ_W-1:0]          d_sqx_r, d_sqy_r;
  logic                     d_xneg_r, d_xnz_r, d_yneg_r, d_ynz_r;
  logic [8:0][PIX_W-1:0]    d_pix_r;
  logic [POS_W-1:0]         d_col_r, d_row_r;
  // stage E: selected neighbors
  logic                     e_v_r;
  logic [PIX_W-1:0]         e_s_r, e_e_r;
  logic [POS_W-1:0]         e_col_r, e_row_r;
  // output register
  logic                     m_valid_r;
  logic [OUT_DATA_W-1:0]    m_data_r;

  logic en_c, en_d, en_e, en_out;
  logic fire_c, fire_d, fire_e;

  assign en_out  = !m_valid_r || m_ready;
  assign fire_e  = e_v_r && en_out;
  assign en_e    = !e_v_r || fire_e;
  assign fire_d  = d_v_r && en_e;
  assign en_d    = !d_v_r || fire_d;
  assign fire_c  = c_v_r && en_d;
  assign en_c    = !c_v_r || fire_c;
  assign s_ready = en_c;

  logic signed [GRAD_W-1:0] fx, fy;
  always_comb begin
    fy = (sx(s_item.pix[0]) - sx(s_item.pix[6]))
       + ((sx(s_item.pix[1]) - sx(s_item.pix[7])) <<< 1)
       + (sx(s_item.pix[2]) - sx(s_item.pix[8]));
    fx = (sx(s_item.pix[2]) - sx(s_item.pix[0]))
       + ((sx(s_item.pix[5]) - sx(s_item.pix[3])) <<< 1)
       + (sx(s_item.pix[8]) - sx(s_item.pix[6]));
  end

  logic signed [GRAD_W-1:0] nfx, nfy;
  logic [GRAD_W-2:0]        ax, ay;
  always_comb begin
    nfx = -c_fx_r;
    nfy = -c_fy_r;
    ax  = c_fx_r[GRAD_W-1] ? nfx[GRAD_W-2:0] : c_fx_r[GRAD_W-2:0];
    ay  = c_fy_r[GRAD_W-1] ? nfy[GRAD_W-2:0] : c_fy_r[GRAD_W-2:0];
  end

  // 3*f^2 >= g^2 picks the step along each axis
  logic [SQ_W+1:0] tri_x, tri_y;
  step_t           dx, dy;
  logic [PIX_W-1:0] sel_s, sel_e;
  always_comb begin
    tri_x = {2'b00, d_sqx_r} + {1'b0, d_sqx_r, 1'b0};
    tri_y = {2'b00, d_sqy_r} + {1'b0, d_sqy_r, 1'b0};
    dx = STEP_ZERO;
    dy = STEP_ZERO;
    if (tri_x >= {2'b00, d_sqy_r}) begin
      dx = d_xneg_r ? STEP_NEG : (d_xnz_r ? STEP_POS : STEP_ZERO);
    end
    if (tri_y >= {2'b00, d_sqx_r}) begin
      dy = d_yneg_r ? STEP_NEG : (d_ynz_r ? STEP_POS : STEP_ZERO);
    end
    case ({dx, dy})
      {STEP_POS,  STEP_ZERO}: begin sel_s = d_pix_r[5]; sel_e = d_pix_r[3]; end
      {STEP_NEG,  STEP_ZERO}: begin sel_s = d_pix_r[3]; sel_e = d_pix_r[5]; end
      {STEP_ZERO, STEP_POS }: begin sel_s = d_pix_r[7]; sel_e = d_pix_r[1]; end
      {STEP_ZERO, STEP_NEG }: begin sel_s = d_pix_r[1]; sel_e = d_pix_r[7]; end
      {STEP_POS,  STEP_POS }: begin sel_s = d_pix_r[8]; sel_e = d_pix_r[0]; end
      {STEP_NEG,  STEP_NEG }: begin sel_s = d_pix_r[0]; sel_e = d_pix_r[8]; end
      {STEP_POS,  STEP_NEG }: begin sel_s = d_pix_r[2]; sel_e = d_pix_r[6]; end
      {STEP_NEG,  STEP_POS }: begin sel_s = d_pix_r[6]; sel_e = d_pix_r[2]; end
      default:                begin sel_s = d_pix_r[4]; sel_e = d_pix_r[4]; end
    endcase
  end

  logic [PIX_W-1:0] absd;
  logic             is_edge;
  always_comb begin
    absd    = (e_e_r >= e_s_r) ? (e_e_r - e_s_r) : (e_s_r - e_e_r);
    is_edge = absd > thr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r     <= 1'b0;
      d_v_r     <= 1'b0;
      e_v_r     <= 1'b0;
      m_valid_r <= 1'b0;
    end else begin
      if (en_c)   c_v_r     <= s_valid;
      if (en_d)   d_v_r     <= c_v_r;
      if (en_e)   e_v_r     <= d_v_r;
      if (en_out) m_valid_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && s_valid) begin
      c_fx_r  <= fx;
      c_fy_r  <= fy;
      c_pix_r <= s_item.pix;
      c_col_r <= s_item.col;
      c_row_r <= s_item.row;
    end
    if (fire_c) begin
      d_sqx_r  <= SQ_W'(ax) * SQ_W'(ax);
      d_sqy_r  <= SQ_W'(ay) * SQ_W'(ay);
      d_xneg_r <= c_fx_r[GRAD_W-1];
      d_yneg_r <= c_fy_r[GRAD_W-1];
      d_xnz_r  <= c_fx_r != '0;
      d_ynz_r  <= c_fy_r != '0;
      d_pix_r  <= c_pix_r;
      d_col_r  <= c_col_r;
      d_row_r  <= c_row_r;
    end
    if (fire_d) begin
      e_s_r   <= sel_s;
      e_e_r   <= sel_e;
      e_col_r <= d_col_r;
      e_row_r <= d_row_r;
    end
    if (fire_e) begin
      m_data_r <= {{(OUT_DATA_W - 2 * POS_W - 1){1'b0}}, is_edge, e_row_r, e_col_r};
    end
  end

  assign m_valid = m_valid_r;
  assign m_data  = m_data_r;

endmodule

`default_nettype wire

FILE: rtl/sdem_checker.sv
// Port-level checks of the edge marker top level, bound into it.
`default_nettype none

module sdem_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [sdem_pkg::OUT_DATA_W-1:0] out_tdata
);
  import sdem_pkg::*;

  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(out_tvalid && !out_tready)) |-> (out_tvalid && $stable(out_tdata)))
    else $error("stalled output item changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_DATA_W-1:2*POS_W+1] == '0))
    else $error("tdata padding not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind sobel_directional_edge_marker_core sdem_checker u_sdem_checker (.*);

`default_nettype wire
